/* src/brb_pkg.sv */
// Package for the byte ring buffer FIFO: operation codes, result struct and defaults.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package brb_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned CountW       = 10;
  localparam int unsigned OverrunW     = 32;
  localparam int unsigned ByteW        = 8;

  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_READ    = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_DISCARD = 3'd3,
    KIND_FLUSH   = 3'd4
  } brb_kind_e;

  typedef struct packed {
    logic                byte_sel;
    logic                byte_valid;
    logic [CountW-1:0]   moved;
    logic [CountW-1:0]   fill;
    logic [CountW-1:0]   free;
    logic [OverrunW-1:0] overrun;
    logic                empty;
    logic                full;
  } brb_res_t;

endpackage

/* src/brb_mem.sv */
// Byte storage of the ring buffer: one write port, one read port with registered data.
// Depends on brb_pkg for the byte width.
`timescale 1ns / 1ps

module brb_mem #(
  parameter int unsigned DEPTH = brb_pkg::DefaultDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [brb_pkg::ByteW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [brb_pkg::ByteW-1:0] rdata_o
);
  import brb_pkg::*;

  logic [ByteW-1:0] mem_q [DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/brb_ctrl.sv */
// Pointer, fill and overrun logic of the ring buffer; drives the storage ports.
// Depends on brb_pkg for operation codes and the result struct.
`timescale 1ns / 1ps

module brb_ctrl #(
  parameter int unsigned DEPTH = brb_pkg::DefaultDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_i,
  input  logic [2:0]                kind_i,
  input  logic [brb_pkg::ByteW-1:0]  data_byte_i,
  input  logic                      first_of_write_i,
  input  logic [brb_pkg::CountW-1:0] amount_i,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [brb_pkg::ByteW-1:0]  mem_wdata_o,
  output logic [AW-1:0]             mem_raddr_o,
  output brb_pkg::brb_res_t         res_o
);
  import brb_pkg::*;

  localparam int unsigned SW = ((AW > CountW) ? AW : CountW) + 1;

  logic [AW-1:0]       wp_q, wp_d, rp_q, rp_d;
  logic [OverrunW-1:0] ovr_q, ovr_d;
  logic                drop_q, drop_d;

  logic [SW-1:0] fill_pre, fill_post, amount_ext, moved, peek_sum, disc_sum, free_post;
  logic [AW-1:0] peek_addr, wp_inc, wp_d_inc;
  logic          can_push, valid, sel;
  brb_kind_e     kind;

  function automatic logic [SW-1:0] fill_of(logic [AW-1:0] w, logic [AW-1:0] r);
    logic [SW-1:0] diff;
    diff = SW'(w) - SW'(r);
    if (w < r) begin
      diff = diff + SW'(DEPTH);
    end
    return diff;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // pointer plus an offset below DEPTH, folded back into range
  function automatic logic [SW-1:0] wrap_add(logic [AW-1:0] p, logic [SW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(p) + off;
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s;
  endfunction

  assign kind       = brb_kind_e'(kind_i);
  assign fill_pre   = fill_of(wp_q, rp_q);
  assign amount_ext = SW'(amount_i);
  assign wp_inc     = ptr_inc(wp_q);
  assign can_push   = fill_pre < SW'(DEPTH - 1);
  assign peek_sum   = wrap_add(rp_q, amount_ext);
  assign peek_addr  = peek_sum[AW-1:0];
  assign disc_sum   = wrap_add(rp_q, (amount_ext < fill_pre) ? amount_ext : fill_pre);

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    ovr_d  = ovr_q;
    drop_d = drop_q;
    moved  = '0;
    valid  = 1'b0;
    sel    = 1'b0;
    unique case (kind)
      KIND_PUSH: begin
        if (first_of_write_i) begin
          drop_d = 1'b0;
        end
        if (can_push) begin
          wp_d  = wp_inc;
          valid = 1'b1;
          moved = SW'(1);
        end else if (!(drop_q && !first_of_write_i)) begin
          ovr_d  = ovr_q + OverrunW'(1);
          drop_d = 1'b1;
        end
      end
      KIND_READ: begin
        if (fill_pre != '0) begin
          rp_d  = ptr_inc(rp_q);
          valid = 1'b1;
          sel   = 1'b1;
          moved = SW'(1);
        end
      end
      KIND_PEEK: begin
        if (amount_ext < fill_pre) begin
          valid = 1'b1;
          sel   = 1'b1;
          moved = SW'(1);
        end
      end
      KIND_DISCARD: begin
        moved = (amount_ext < fill_pre) ? amount_ext : fill_pre;
        rp_d  = disc_sum[AW-1:0];
      end
      KIND_FLUSH: begin
        moved  = fill_pre;
        wp_d   = '0;
        rp_d   = '0;
        ovr_d  = '0;
        drop_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign fill_post = fill_of(wp_d, rp_d);
  assign free_post = SW'(DEPTH - 1) - fill_post;
  assign wp_d_inc  = ptr_inc(wp_d);

  always_comb begin
    res_o            = '0;
    res_o.byte_sel   = sel;
    res_o.byte_valid = valid;
    res_o.moved      = moved[CountW-1:0];
    res_o.fill       = fill_post[CountW-1:0];
    res_o.free       = free_post[CountW-1:0];
    res_o.overrun    = ovr_d;
    res_o.empty      = (wp_d == rp_d);
    res_o.full       = (wp_d_inc == rp_d);
  end

  assign mem_we_o    = req_i && (kind == KIND_PUSH) && can_push;
  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = data_byte_i;
  assign mem_raddr_o = (kind == KIND_READ) ? rp_q : peek_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      ovr_q  <= '0;
      drop_q <= 1'b0;
    end else if (req_i) begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      ovr_q  <= ovr_d;
      drop_q <= drop_d;
    end
  end

endmodule

/* src/byte_ring_buffer_fifo.sv */
// Byte ring buffer FIFO, top level: stream ports, result register, storage and control.
// Depends on brb_pkg, brb_mem and brb_ctrl.
// The result is registered and appears on the master side in the cycle after the request is accepted.
// Throughput: one request per cycle while the master side takes results; storage has a single read port.
// Input is taken whenever the result register is empty or being drained.
// Reset: pointers, overrun count and burst flag clear at once; storage is not cleared.
`timescale 1ns / 1ps

module byte_ring_buffer_fifo #(
  parameter int unsigned DEPTH = brb_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], amount[17:8], zero pad[23:18]
  input  logic [3:0]  s_axis_tuser,  // kind[2:0], first_of_write[3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // byte_out[7:0], moved_count[17:8], fill_count[27:18],
                                     // free_count[37:28], overrun_total[69:38],
                                     // is_empty[70], is_full[71]
  output logic [0:0]  m_axis_tuser   // byte_valid[0]
);
  import brb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic             req;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [ByteW-1:0] mem_wdata, mem_rdata, byte_out;
  brb_res_t         res, res_q;
  logic             out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign req           = s_axis_tvalid && s_axis_tready;

  brb_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .kind_i          (s_axis_tuser[2:0]),
    .data_byte_i     (s_axis_tdata[7:0]),
    .first_of_write_i(s_axis_tuser[3]),
    .amount_i        (s_axis_tdata[17:8]),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .res_o           (res)
  );

  brb_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (req),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req) begin
      res_q <= res;
    end
  end

  assign byte_out      = res_q.byte_sel ? mem_rdata : '0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.full, res_q.empty, res_q.overrun, res_q.free,
                          res_q.fill, res_q.moved, byte_out};
  assign m_axis_tuser  = res_q.byte_valid;

endmodule

/* sim/byte_ring_buffer_fifo_test.sv */
// Self-checking bench for byte_ring_buffer_fifo: directed table, then random request episodes.
// Each accepted request is run through a local ring model; results are checked in order.
// Depends on brb_pkg and the RTL under src.
`timescale 1ns / 1ps

module byte_ring_buffer_fifo_test;
  import brb_pkg::*;

  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam logic [9:0] MAX_FILL     = 10'(DefaultDepth - 1);
  localparam int IdleMax        = 18;
  localparam int WatchdogLimit  = 500;
  localparam int RandomRequests = 240;
  localparam int ReportCap      = 60;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       first_of_write;
    logic [9:0] amount;
  } request_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic [9:0]  moved;
    logic [9:0]  fill;
    logic [9:0]  free;
    logic [31:0] overrun;
    logic        empty;
    logic        full;
  } status_t;

  typedef struct {
    request_t rq;
    bit       typed;
    status_t  res;
  } dir_row_t;

  typedef enum int {EP_BURST, EP_DRAIN, EP_PEEK, EP_DISCARD, EP_FLUSH, EP_NOISE} episode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  byte_ring_buffer_fifo #(.DEPTH(DefaultDepth)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // ring model state
  logic [7:0]  ring_mem [DefaultDepth];
  logic [9:0]  wr_ptr     = '0;
  logic [9:0]  rd_ptr     = '0;
  logic [31:0] overruns   = '0;
  bit          burst_lost = 1'b0;

  status_t   expected_q [$];
  dir_row_t  dir_table [$];
  int        mismatches    = 0;
  int        requests_sent = 0;
  int        stuck_cycles  = 0;
  bit        calm          = 1'b0;

  always #5 clk_i = ~clk_i;

  function automatic status_t ring_step(request_t rq);
    status_t    s;
    logic [9:0] fill;
    logic [9:0] idx;
    s    = '0;
    fill = wr_ptr - rd_ptr;
    case (rq.kind)
      KIND_PUSH: begin
        if (rq.first_of_write) burst_lost = 1'b0;
        if (fill != MAX_FILL) begin
          ring_mem[wr_ptr] = rq.data;
          wr_ptr           = wr_ptr + 10'd1;
          s.byte_valid     = 1'b1;
          s.moved          = 10'd1;
        end else if (!burst_lost) begin
          overruns   = overruns + 32'd1;
          burst_lost = 1'b1;
        end
      end
      KIND_READ: begin
        if (fill != 10'd0) begin
          s.byte_out   = ring_mem[rd_ptr];
          rd_ptr       = rd_ptr + 10'd1;
          s.byte_valid = 1'b1;
          s.moved      = 10'd1;
        end
      end
      KIND_PEEK: begin
        if (rq.amount < fill) begin
          idx          = rd_ptr + rq.amount;
          s.byte_out   = ring_mem[idx];
          s.byte_valid = 1'b1;
          s.moved      = 10'd1;
        end
      end
      KIND_DISCARD: begin
        s.moved = (rq.amount < fill) ? rq.amount : fill;
        rd_ptr  = rd_ptr + s.moved;
      end
      KIND_FLUSH: begin
        s.moved    = fill;
        wr_ptr     = '0;
        rd_ptr     = '0;
        overruns   = '0;
        burst_lost = 1'b0;
      end
      default: ;
    endcase
    fill      = wr_ptr - rd_ptr;
    s.fill    = fill;
    s.free    = MAX_FILL - fill;
    s.overrun = overruns;
    s.empty   = (wr_ptr == rd_ptr);
    s.full    = ((wr_ptr + 10'd1) == rd_ptr);
    return s;
  endfunction

  function automatic request_t mk_req(logic [2:0] kind, logic [7:0] data, logic first_of_write,
                                      logic [9:0] amount);
    request_t rq;
    rq.kind           = kind;
    rq.data           = data;
    rq.first_of_write = first_of_write;
    rq.amount         = amount;
    return rq;
  endfunction

  function automatic status_t status_at(int byte_out, int byte_valid, int moved,
                                        int fill, int overrun);
    status_t s;
    s.byte_out   = 8'(byte_out);
    s.byte_valid = 1'(byte_valid);
    s.moved      = 10'(moved);
    s.fill       = 10'(fill);
    s.free       = MAX_FILL - 10'(fill);
    s.overrun    = 32'(overrun);
    s.empty      = (fill == 0);
    s.full       = (10'(fill) == MAX_FILL);
    return s;
  endfunction

  function automatic dir_row_t row(logic [2:0] kind, logic [7:0] data, logic first_of_write,
                                   logic [9:0] amount, bit typed = 1'b0, status_t res = '0);
    dir_row_t r;
    r.rq    = mk_req(kind, data, first_of_write, amount);
    r.typed = typed;
    r.res   = res;
    return r;
  endfunction

  function automatic int draw_idle();
    if (calm) return 0;
    return $urandom_range(0, IdleMax);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= ReportCap)
      $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // drive one request; the model steps at the accepting edge
  task automatic send_request(request_t rq, bit typed = 1'b0, status_t res = '0);
    int      gap;
    status_t predicted;
    gap = draw_idle();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, rq.amount, rq.data};
    s_axis_tuser  <= {rq.first_of_write, rq.kind};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predicted = ring_step(rq);
    expected_q.push_back(typed ? res : predicted);
    requests_sent++;
  endtask

  // push until full, then churn at the top with overrunning bursts, reads and deep peeks
  task automatic fill_to_full();
    int         len;
    int         pick;
    logic [9:0] fill;
    fill = wr_ptr - rd_ptr;
    while (fill != MAX_FILL) begin
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++)
        send_request(mk_req(KIND_PUSH, 8'($urandom), i == 0, 10'($urandom)));
      fill = wr_ptr - rd_ptr;
    end
    for (int i = 0; i < 24; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        send_request(mk_req(KIND_PUSH, 8'($urandom), $urandom_range(0, 2) == 0, '0));
      else if (pick < 7)
        send_request(mk_req(KIND_READ, '0, 1'b0, '0));
      else
        send_request(mk_req(KIND_PEEK, '0, 1'b0, 10'($urandom_range(1000, 1023))));
    end
  endtask

  // result side: random back-pressure per result
  initial begin : result_sink
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin : result_check
    status_t got;
    status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.byte_out   = m_axis_tdata[7:0];
      got.moved      = m_axis_tdata[17:8];
      got.fill       = m_axis_tdata[27:18];
      got.free       = m_axis_tdata[37:28];
      got.overrun    = m_axis_tdata[69:38];
      got.empty      = m_axis_tdata[70];
      got.full       = m_axis_tdata[71];
      got.byte_valid = m_axis_tuser[0];
      if (expected_q.size() == 0) begin
        report_mismatch("result with no pending request, fill", 32'(got.fill), '0);
      end else begin
        want = expected_q.pop_front();
        if (got.byte_out !== want.byte_out)
          report_mismatch("byte_out", 32'(got.byte_out), 32'(want.byte_out));
        if (got.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
        if (got.moved !== want.moved)
          report_mismatch("moved_count", 32'(got.moved), 32'(want.moved));
        if (got.fill !== want.fill)
          report_mismatch("fill_count", 32'(got.fill), 32'(want.fill));
        if (got.free !== want.free)
          report_mismatch("free_count", 32'(got.free), 32'(want.free));
        if (got.overrun !== want.overrun)
          report_mismatch("overrun_total", got.overrun, want.overrun);
        if (got.empty !== want.empty)
          report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
        if (got.full !== want.full)
          report_mismatch("is_full", 32'(got.full), 32'(want.full));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WatchdogLimit) begin
      $display("byte_ring_buffer_fifo: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int         fill_requests;
    int         mark;
    int         len;
    int         pick;
    bit         second_fill;
    episode_e   episode;
    logic [9:0] fill;
    logic [9:0] amount;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    rst_ni        <= 1'b0;
    fill_requests = 0;
    second_fill   = 1'b0;

    // empty buffer, spare kinds, small pushes, peek bounds, discard saturation, flush
    dir_table.push_back(row(KIND_READ,    8'h00, 1'b0, 10'd0,    1'b1, status_at(8'h00, 0, 0, 0, 0)));
    dir_table.push_back(row(KIND_PEEK,    8'h00, 1'b0, 10'd0,    1'b1, status_at(8'h00, 0, 0, 0, 0)));
    dir_table.push_back(row(KIND_DISCARD, 8'h00, 1'b0, 10'd1023, 1'b1, status_at(8'h00, 0, 0, 0, 0)));
    dir_table.push_back(row(KIND_FLUSH,   8'h00, 1'b0, 10'd0,    1'b1, status_at(8'h00, 0, 0, 0, 0)));
    dir_table.push_back(row(KIND_SPARE_5, 8'hFF, 1'b1, 10'd1023, 1'b1, status_at(8'h00, 0, 0, 0, 0)));
    dir_table.push_back(row(KIND_SPARE_6, 8'h00, 1'b0, 10'd0,    1'b1, status_at(8'h00, 0, 0, 0, 0)));
    dir_table.push_back(row(KIND_SPARE_7, 8'hFF, 1'b1, 10'd512,  1'b1, status_at(8'h00, 0, 0, 0, 0)));
    dir_table.push_back(row(KIND_PUSH,    8'h00, 1'b1, 10'd0,    1'b1, status_at(8'h00, 1, 1, 1, 0)));
    dir_table.push_back(row(KIND_PUSH,    8'hFF, 1'b0, 10'd1023, 1'b1, status_at(8'h00, 1, 1, 2, 0)));
    dir_table.push_back(row(KIND_PUSH,    8'hA5, 1'b1, 10'd0,    1'b1, status_at(8'h00, 1, 1, 3, 0)));
    dir_table.push_back(row(KIND_PEEK,    8'h00, 1'b0, 10'd0));
    dir_table.push_back(row(KIND_PEEK,    8'h00, 1'b0, 10'd2));
    dir_table.push_back(row(KIND_PEEK,    8'h00, 1'b0, 10'd3));
    dir_table.push_back(row(KIND_PEEK,    8'h00, 1'b0, 10'd1023));
    dir_table.push_back(row(KIND_READ,    8'h00, 1'b0, 10'd0));
    dir_table.push_back(row(KIND_DISCARD, 8'h00, 1'b0, 10'd0));
    dir_table.push_back(row(KIND_DISCARD, 8'h00, 1'b0, 10'd1));
    dir_table.push_back(row(KIND_PUSH,    8'h5A, 1'b1, 10'd0));
    dir_table.push_back(row(KIND_DISCARD, 8'h00, 1'b0, 10'd1023));
    dir_table.push_back(row(KIND_READ,    8'h00, 1'b0, 10'd0));
    dir_table.push_back(row(KIND_PUSH,    8'h3C, 1'b1, 10'd0));
    dir_table.push_back(row(KIND_PUSH,    8'hC3, 1'b0, 10'd0));
    dir_table.push_back(row(KIND_FLUSH,   8'h00, 1'b0, 10'd0,    1'b1, status_at(8'h00, 0, 2, 0, 0)));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) send_request(dir_table[i].rq, dir_table[i].typed, dir_table[i].res);

    while (requests_sent - dir_table.size() - fill_requests < RandomRequests) begin
      calm = ($urandom_range(0, 4) == 0);
      if (!second_fill &&
          requests_sent - dir_table.size() - fill_requests >= RandomRequests / 2) begin
        second_fill = 1'b1;
        mark        = requests_sent;
        fill_to_full();
        fill_requests += requests_sent - mark;
      end
      pick = $urandom_range(0, 99);
      if (pick < 32)      episode = EP_BURST;
      else if (pick < 52) episode = EP_DRAIN;
      else if (pick < 66) episode = EP_PEEK;
      else if (pick < 76) episode = EP_DISCARD;
      else if (pick < 79) episode = EP_FLUSH;
      else                episode = EP_NOISE;
      fill = wr_ptr - rd_ptr;
      case (episode)
        EP_BURST: begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++)
            send_request(mk_req(KIND_PUSH, 8'($urandom),
                                (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0),
                                10'($urandom)));
        end
        EP_DRAIN: begin
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++)
            send_request(mk_req(KIND_READ, 8'($urandom), 1'($urandom), 10'($urandom)));
        end
        EP_PEEK: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 3) == 0) amount = 10'($urandom);
            else                           amount = 10'($urandom_range(0, fill));
            send_request(mk_req(KIND_PEEK, 8'($urandom), 1'($urandom), amount));
          end
        end
        EP_DISCARD: begin
          if ($urandom_range(0, 3) != 0) amount = 10'($urandom_range(0, 8));
          else                           amount = 10'($urandom);
          send_request(mk_req(KIND_DISCARD, 8'($urandom), 1'($urandom), amount));
        end
        EP_FLUSH:
          send_request(mk_req(KIND_FLUSH, 8'($urandom), 1'($urandom), 10'($urandom)));
        default: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            send_request(mk_req(3'($urandom), 8'($urandom), 1'($urandom), 10'($urandom)));
        end
      endcase
    end

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("byte_ring_buffer_fifo: match");
    end else begin
      $display("byte_ring_buffer_fifo: mismatch");
    end
    $finish;
  end

endmodule
